// ===== hw/rtl/ffcte_pkg.sv =====
// package of shared types, constants and hash helpers for the flow filter encoder
`timescale 1ns / 1ps
`default_nettype none
package ffcte_pkg;

    localparam int BLOCK_COUNT_DEF     = 16;
    localparam int CELLS_PER_BLOCK_DEF = 256;
    localparam int FILTER_SIZE_DEF     = 4096;
    localparam int FILTER_HASHES_DEF   = 3;
    localparam int COUNT_WIDTH_DEF     = 32;

    localparam int KEY_BYTES  = 13;
    localparam int SEED_COUNT = 8;
    localparam int ADDR_W     = 2;

    // item kinds
    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_BLOCK_SEED = 2'd0;
    localparam logic [ADDR_W-1:0] REG_CELL_A     = 2'd1;
    localparam logic [ADDR_W-1:0] REG_CELL_B     = 2'd2;
    localparam logic [ADDR_W-1:0] REG_CELL_C     = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [3:0]  read_block;
        logic [7:0]  read_cell;
    } in_item_t;

    typedef struct packed {
        logic        is_new;
        logic [3:0]  block_index;
        logic [7:0]  cell_index_a;
        logic [7:0]  cell_index_b;
        logic [7:0]  cell_index_c;
        logic [31:0] read_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH_KEY,
        ST_HASH_BODY,
        ST_HASH_BODY2,
        ST_HASH_BODY3,
        ST_HASH_MIX1,
        ST_HASH_MIX2,
        ST_HASH_MIX3,
        ST_FILT_RD,
        ST_FILT_WR,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_READ_WAIT,
        ST_CLEAR,
        ST_OUT
    } state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

    // first half of the murmur3 key word scramble, the second multiply
    // runs in the following cycle
    function automatic logic [31:0] key_premix(input logic [31:0] k);
        key_premix = rotl(k * 32'hcc9e2d51, 15);
    endfunction

    // one murmur3 body round on an already xored hash word
    function automatic logic [31:0] hash_round(input logic [31:0] h);
        hash_round = rotl(h, 13) * 32'd5 + 32'he6546b64;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ffcte_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ffcte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/flow_filter_count_table_encoder.sv =====
// top level: murmur hashing, flow filter and count table read-modify-write
//
//  channel | dir | handshake        | beat
//  in      | in  | in_valid/ready   | in_item_t
//  out     | out | out_valid/ready  | out_item_t
//  apb     | in  | psel/penable     | seed registers
//
// packet: key scramble, body rounds and finalization (ST_HASH_KEY to ST_HASH_MIX3),
// a read and a write per filter bit and per count cell, and the result in ST_OUT;
// ST_IDLE comes between ST_OUT and the next beat. read: ST_READ_WAIT, then ST_OUT;
// unused kind: ST_OUT; clear: max(FILTER_SIZE, BLOCK_COUNT*CELLS_PER_BLOCK) entries,
// one entry a cycle, then ST_OUT. Reset runs the same clearing pass with no result.
// A result still held at the output stalls the next one in ST_OUT.
`timescale 1ns / 1ps
`default_nettype none
module flow_filter_count_table_encoder
    import ffcte_pkg::*;
#(
    parameter int BLOCK_COUNT     = BLOCK_COUNT_DEF,
    parameter int CELLS_PER_BLOCK = CELLS_PER_BLOCK_DEF,
    parameter int FILTER_SIZE     = FILTER_SIZE_DEF,
    parameter int FILTER_HASHES   = FILTER_HASHES_DEF,
    parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_item,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W+1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);
    localparam int FW     = $clog2(FILTER_SIZE);
    localparam int BW     = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int CW     = $clog2(CELLS_PER_BLOCK);
    localparam int CDEPTH = BLOCK_COUNT * CELLS_PER_BLOCK;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int CLRN   = (CDEPTH > FILTER_SIZE) ? CDEPTH : FILTER_SIZE;
    localparam int CLRW   = $clog2(CLRN + 1);
    localparam int NH     = FILTER_HASHES + 4;
    localparam int HW     = $clog2(NH + 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // seed registers
    logic [3:0] seed_reg [4];
    wire wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg[0] <= 4'd0;
            seed_reg[1] <= 4'd1;
            seed_reg[2] <= 4'd2;
            seed_reg[3] <= 4'd3;
        end
        else if (wr_en)
        begin
            unique case (paddr[ADDR_W+1:2])
                REG_BLOCK_SEED: seed_reg[0] <= pwdata[3:0];
                REG_CELL_A:     seed_reg[1] <= pwdata[3:0];
                REG_CELL_B:     seed_reg[2] <= pwdata[3:0];
                REG_CELL_C:     seed_reg[3] <= pwdata[3:0];
                default: ;
            endcase
        end
    end
    always_comb
    begin
        prdata = {28'd0, seed_reg[paddr[ADDR_W+1:2]]};
    end

    // control and payload registers
    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [31:0] h_reg [NH];
    logic [31:0] k_reg [4];
    logic [HW-1:0] idx_reg;
    logic [CLRW-1:0] clr_reg;
    logic fresh_reg;
    logic boot_reg;
    out_item_t out_reg, out_next;
    logic out_valid_reg;

    // seed for hash lane j: filter lanes use j, then block and cells
    function automatic logic [31:0] lane_seed(input int j, input logic [3:0] s [4]);
        if (j < FILTER_HASHES) lane_seed = 32'(j);
        else lane_seed = {28'd0, s[j-FILTER_HASHES]};
    endfunction

    // memories
    logic           f_we, f_wd, f_rd;
    logic [FW-1:0]  f_addr;
    logic           c_we;
    logic [CAW-1:0] c_addr;
    logic [COUNT_WIDTH-1:0] c_wd, c_rd;

    ffcte_ram #(.WIDTH(1), .DEPTH(FILTER_SIZE)) u_filter (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));
    ffcte_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CDEPTH)) u_cells (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));

    wire [BW-1:0] blk      = h_reg[FILTER_HASHES][BW-1:0];
    wire [2:0]    cidx     = 3'(idx_reg);
    wire [CW-1:0] cell_sel = h_reg[FILTER_HASHES + 1 + 32'(cidx)][CW-1:0];
    wire          rd_ok = (32'(item_reg.read_block) < BLOCK_COUNT)
                       && (32'(item_reg.read_cell) < CELLS_PER_BLOCK);
    wire          out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // memory addressing and write data
    always_comb
    begin
        f_we   = 1'b0;
        f_wd   = 1'b1;
        f_addr = h_reg[idx_reg][FW-1:0];
        c_we   = 1'b0;
        c_addr = CAW'({blk, cell_sel});
        c_wd   = (c_rd == CMAX) ? c_rd : c_rd + 1'b1;
        if (CELLS_PER_BLOCK > 0)
        begin
            c_addr = CAW'(32'(blk) * CELLS_PER_BLOCK + 32'(cell_sel));
        end
        unique case (state_reg)
            ST_FILT_WR: f_we = 1'b1;
            ST_CELL_WR: c_we = 1'b1;
            ST_READ_WAIT, ST_OUT, ST_IDLE:
            begin
                c_addr = CAW'(32'(item_reg.read_block) * CELLS_PER_BLOCK
                              + 32'(item_reg.read_cell));
            end
            ST_CLEAR:
            begin
                f_we   = clr_reg < CLRW'(FILTER_SIZE);
                f_wd   = 1'b0;
                f_addr = clr_reg[FW-1:0];
                c_we   = clr_reg < CLRW'(CDEPTH);
                c_wd   = '0;
                c_addr = clr_reg[CAW-1:0];
            end
            default: ;
        endcase
    end

    // result beat for the item in hand
    always_comb
    begin
        out_next = '0;
        if (item_reg.kind == KIND_PACKET)
        begin
            out_next.is_new       = fresh_reg;
            out_next.block_index  = 4'(h_reg[FILTER_HASHES]);
            out_next.cell_index_a = 8'(h_reg[FILTER_HASHES + 1]);
            out_next.cell_index_b = 8'(h_reg[FILTER_HASHES + 2]);
            out_next.cell_index_c = 8'(h_reg[FILTER_HASHES + 3]);
        end
        else if (item_reg.kind == KIND_READ)
        begin
            out_next.block_index  = item_reg.read_block;
            out_next.cell_index_a = item_reg.read_cell;
            out_next.read_count   = rd_ok ? 32'(c_rd) : 32'd0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (in_item.kind)
                        KIND_PACKET: state_next = ST_HASH_KEY;
                        KIND_READ:   state_next = ST_READ_WAIT;
                        KIND_CLEAR:  state_next = ST_CLEAR;
                        default:     state_next = ST_OUT;
                    endcase
                end
            end
            ST_HASH_KEY:   state_next = ST_HASH_BODY;
            ST_HASH_BODY:  state_next = ST_HASH_BODY2;
            ST_HASH_BODY2: state_next = ST_HASH_BODY3;
            ST_HASH_BODY3: state_next = ST_HASH_MIX1;
            ST_HASH_MIX1:  state_next = ST_HASH_MIX2;
            ST_HASH_MIX2:  state_next = ST_HASH_MIX3;
            ST_HASH_MIX3:  state_next = ST_FILT_RD;
            ST_FILT_RD:    state_next = ST_FILT_WR;
            ST_FILT_WR:    state_next = (idx_reg == HW'(FILTER_HASHES - 1))
                                        ? ST_CELL_RD : ST_FILT_RD;
            ST_CELL_RD:    state_next = ST_CELL_WR;
            ST_CELL_WR:    state_next = (idx_reg == HW'(2)) ? ST_OUT : ST_CELL_RD;
            ST_READ_WAIT:  state_next = ST_OUT;
            ST_CLEAR:
            begin
                if (clr_reg == CLRW'(CLRN - 1))
                begin
                    state_next = boot_reg ? ST_IDLE : ST_OUT;
                end
            end
            ST_OUT:        state_next = out_load ? ST_IDLE : ST_OUT;
            default:       state_next = ST_IDLE;
        endcase
    end

    // sequencing and hash datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            fresh_reg     <= 1'b0;
            boot_reg      <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            // output register: load a new beat or drop the taken one
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    item_reg  <= in_item;
                    idx_reg   <= '0;
                    clr_reg   <= '0;
                    fresh_reg <= 1'b0;
                    k_reg[0] <= key_premix({in_item.src_ip});
                    k_reg[1] <= key_premix({in_item.dst_ip});
                    k_reg[2] <= key_premix({in_item.dst_port, in_item.src_port});
                    k_reg[3] <= key_premix({24'd0, in_item.protocol});
                end
                ST_HASH_KEY:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        k_reg[i] <= k_reg[i] * 32'h1b873593;
                    end
                end
                ST_HASH_BODY:
                begin
                    for (int j = 0; j < NH; j++)
                    begin
                        h_reg[j] <= hash_round(lane_seed(j, seed_reg) ^ k_reg[0]);
                    end
                end
                ST_HASH_BODY2:
                begin
                    for (int j = 0; j < NH; j++)
                    begin
                        h_reg[j] <= hash_round(h_reg[j] ^ k_reg[1]);
                    end
                end
                ST_HASH_BODY3:
                begin
                    // last full word, tail byte, length and first fold
                    for (int j = 0; j < NH; j++)
                    begin
                        logic [31:0] h;
                        h = hash_round(h_reg[j] ^ k_reg[2]);
                        h = h ^ k_reg[3] ^ 32'(KEY_BYTES);
                        h_reg[j] <= h ^ (h >> 16);
                    end
                end
                ST_HASH_MIX1:
                begin
                    for (int j = 0; j < NH; j++)
                    begin
                        h_reg[j] <= h_reg[j] * 32'h85ebca6b;
                    end
                end
                ST_HASH_MIX2:
                begin
                    for (int j = 0; j < NH; j++)
                    begin
                        h_reg[j] <= (h_reg[j] ^ (h_reg[j] >> 13)) * 32'hc2b2ae35;
                    end
                end
                ST_HASH_MIX3:
                begin
                    // final fold, then reduce each lane to its range
                    for (int j = 0; j < NH; j++)
                    begin
                        logic [31:0] h;
                        h = h_reg[j] ^ (h_reg[j] >> 16);
                        if (j < FILTER_HASHES) h_reg[j] <= h % FILTER_SIZE;
                        else if (j == FILTER_HASHES) h_reg[j] <= h % BLOCK_COUNT;
                        else h_reg[j] <= h % CELLS_PER_BLOCK;
                    end
                end
                ST_FILT_WR:
                begin
                    if (!f_rd) fresh_reg <= 1'b1;
                    idx_reg <= (idx_reg == HW'(FILTER_HASHES - 1)) ? '0 : idx_reg + 1'b1;
                end
                ST_CELL_WR:
                begin
                    idx_reg <= (idx_reg == HW'(2)) ? '0 : idx_reg + 1'b1;
                end
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLRW'(CLRN - 1))
                    begin
                        boot_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== verif/flow_filter_count_table_encoder_test.sv =====
// self-checking testbench for the flow filter and count table encoder
`timescale 1ns / 1ps
`default_nettype none
module flow_filter_count_table_encoder_test;
    import ffcte_pkg::*;

    localparam int NUM_BLOCKS  = 16;
    localparam int NUM_CELLS   = 256;
    localparam int FILT_BITS   = 4096;
    localparam int FILT_HASHES = 3;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 25000000;
    localparam int SETTLE_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic out_valid;
    logic out_ready;
    out_item_t out_item;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W+1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // shadow of the block state
    logic        shadow_filter [FILT_BITS];
    logic [31:0] shadow_cells [NUM_BLOCKS*NUM_CELLS];
    logic [3:0]  shadow_seed [4];

    out_item_t expected_results[$];
    int  error_count;
    longint cycle_count;
    bit  stall_out;

    flow_filter_count_table_encoder u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("flow_filter_count_table_encoder_test failed");
            $finish;
        end
    end

    function automatic logic [31:0] rot_left(logic [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(logic [31:0] k);
        k = k * 32'hcc9e2d51;
        k = rot_left(k, 15);
        return k * 32'h1b873593;
    endfunction

    // murmur3 x86_32 over the 13 byte little-endian flow key
    function automatic logic [31:0] flow_hash(in_item_t it, logic [31:0] seed);
        logic [31:0] h;
        logic [31:0] words [3];
        words[0] = it.src_ip;
        words[1] = it.dst_ip;
        words[2] = {it.dst_port, it.src_port};
        h = seed;
        for (int i = 0; i < 3; i++)
        begin
            h ^= scramble_word(words[i]);
            h = rot_left(h, 13);
            h = h * 32'd5 + 32'he6546b64;
        end
        h ^= scramble_word({24'd0, it.protocol});
        h ^= 32'd13;
        h ^= h >> 16;
        h *= 32'h85ebca6b;
        h ^= h >> 13;
        h *= 32'hc2b2ae35;
        h ^= h >> 16;
        return h;
    endfunction

    task automatic clear_shadow();
        foreach (shadow_filter[i]) shadow_filter[i] = 1'b0;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
    endtask

    task automatic bump_cell(int blk, int cell_idx);
        int a;
        a = blk * NUM_CELLS + cell_idx;
        if (shadow_cells[a] != 32'hffffffff)
            shadow_cells[a] = shadow_cells[a] + 1;
    endtask

    // update the shadow and work out the result of one item
    task automatic predict_encode(in_item_t it, output out_item_t res);
        logic [31:0] f;
        int blk;
        res = '0;
        case (it.kind)
            KIND_PACKET:
            begin
                for (int i = 0; i < FILT_HASHES; i++)
                begin
                    f = flow_hash(it, i) % FILT_BITS;
                    if (!shadow_filter[f])
                    begin
                        shadow_filter[f] = 1'b1;
                        res.is_new = 1'b1;
                    end
                end
                blk = int'(flow_hash(it, shadow_seed[REG_BLOCK_SEED]) % NUM_BLOCKS);
                res.block_index  = 4'(blk);
                res.cell_index_a = 8'(flow_hash(it, shadow_seed[REG_CELL_A]) % NUM_CELLS);
                res.cell_index_b = 8'(flow_hash(it, shadow_seed[REG_CELL_B]) % NUM_CELLS);
                res.cell_index_c = 8'(flow_hash(it, shadow_seed[REG_CELL_C]) % NUM_CELLS);
                bump_cell(blk, res.cell_index_a);
                bump_cell(blk, res.cell_index_b);
                bump_cell(blk, res.cell_index_c);
            end
            KIND_READ:
            begin
                res.block_index  = it.read_block;
                res.cell_index_a = it.read_cell;
                res.read_count   = shadow_cells[it.read_block * NUM_CELLS + it.read_cell];
            end
            KIND_CLEAR:
                clear_shadow();
            default:
                ;
        endcase
    endtask

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return;
        else if (r < 95)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clk);
        end
    endtask

    // send one beat and record its expected result
    task automatic send_item(in_item_t it, bit gaps);
        out_item_t res;
        if (gaps)
            idle_gap();
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_encode(it, res);
        expected_results = {expected_results, res};
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_seed(logic [ADDR_W-1:0] idx, logic [3:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (pready !== 1'b1)
        begin
            $error("pready exp 1 got %0d", pready);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_seed[idx] = value;
        @(negedge clk);
    endtask

    // read a seed register back over the configuration port
    task automatic check_seed(logic [ADDR_W-1:0] idx);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {28'd0, shadow_seed[idx]})
        begin
            $error("prdata exp %0d got %0d", shadow_seed[idx], prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    function automatic in_item_t random_packet();
        in_item_t it;
        it = '0;
        it.kind     = KIND_PACKET;
        it.src_ip   = $urandom;
        it.dst_ip   = $urandom;
        it.src_port = 16'($urandom);
        it.dst_port = 16'($urandom);
        it.protocol = 8'($urandom);
        return it;
    endfunction

    function automatic in_item_t read_of(logic [3:0] blk, logic [7:0] cell_idx);
        in_item_t it;
        it = '0;
        it.kind       = KIND_READ;
        it.read_block = blk;
        it.read_cell  = cell_idx;
        return it;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        out_item_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat %h", out_item);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (out_item.is_new !== exp_res.is_new)
                    $error("is_new exp %0d got %0d", exp_res.is_new, out_item.is_new);
                if (out_item.block_index !== exp_res.block_index)
                    $error("block_index exp %0d got %0d", exp_res.block_index,
                           out_item.block_index);
                if (out_item.cell_index_a !== exp_res.cell_index_a)
                    $error("cell_index_a exp %0d got %0d", exp_res.cell_index_a,
                           out_item.cell_index_a);
                if (out_item.cell_index_b !== exp_res.cell_index_b)
                    $error("cell_index_b exp %0d got %0d", exp_res.cell_index_b,
                           out_item.cell_index_b);
                if (out_item.cell_index_c !== exp_res.cell_index_c)
                    $error("cell_index_c exp %0d got %0d", exp_res.cell_index_c,
                           out_item.cell_index_c);
                if (out_item.read_count !== exp_res.read_count)
                    $error("read_count exp %0d got %0d", exp_res.read_count,
                           out_item.read_count);
                if (out_item !== exp_res)
                    error_count++;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (!stall_out)
            out_ready <= 1'b1;
        else if (r < 60)
            out_ready <= 1'b1;
        else if (r < 97)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clk);
        end
    end

    // extremes of every field, each kind, saturation-free corner cases
    task automatic test_directed();
        in_item_t it;
        out_item_t dummy;
        it = '0;
        send_item(it, 1'b0);
        send_item(it, 1'b0);
        it = '1;
        it.kind = KIND_PACKET;
        send_item(it, 1'b0);
        it = random_packet();
        send_item(it, 1'b0);
        send_item(it, 1'b0);
        // read back cell a of the block that packet touched
        predict_encode(read_of(0, 0), dummy);
        send_item(read_of(4'(flow_hash(it, shadow_seed[REG_BLOCK_SEED]) % NUM_BLOCKS),
                          8'(flow_hash(it, shadow_seed[REG_CELL_A]) % NUM_CELLS)), 1'b0);
        send_item(read_of(4'hf, 8'hff), 1'b0);
        send_item(read_of(4'h0, 8'h00), 1'b0);
        it = '1;
        it.kind = KIND_READ;
        send_item(it, 1'b0);
        it = '1;
        it.kind = KIND_UNUSED;
        send_item(it, 1'b0);
        it = '0;
        it.kind = KIND_CLEAR;
        it.src_ip = '1;
        send_item(it, 1'b0);
        send_item(read_of(4'h0, 8'h00), 1'b0);
    endtask

    // flows that repeat so filter hits and counts build up
    task automatic test_random(int count);
        in_item_t flows[$];
        in_item_t it;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 199);
            if (r < 90 || flows.size() == 0)
            begin
                it = random_packet();
                if ($urandom_range(0, 3) == 0)
                    it.read_block = 4'($urandom);
                if ($urandom_range(0, 3) == 0)
                    it.read_cell = 8'($urandom);
                flows = {flows, it};
                if (flows.size() > 40)
                    void'(flows.pop_front());
            end
            else if (r < 160)
                it = flows[$urandom_range(0, flows.size() - 1)];
            else if (r < 196)
            begin
                it = flows[$urandom_range(0, flows.size() - 1)];
                it = read_of(4'(flow_hash(it, shadow_seed[REG_BLOCK_SEED]) % NUM_BLOCKS),
                             8'(($urandom_range(0, 1) != 0)
                                ? flow_hash(it, shadow_seed[REG_CELL_B]) % NUM_CELLS
                                : $urandom_range(0, 255)));
                it.src_ip = $urandom;
            end
            else if (r < 198)
            begin
                it = random_packet();
                it.kind = KIND_UNUSED;
            end
            else
            begin
                it = random_packet();
                it.kind = KIND_CLEAR;
            end
            send_item(it, 1'b1);
            if (i == count / 2)
                drain();
        end
    endtask

    // seed settings, extremes included
    task automatic test_seeds(logic [3:0] b, logic [3:0] a, logic [3:0] bb, logic [3:0] c,
                              int count);
        drain();
        write_seed(REG_BLOCK_SEED, b);
        write_seed(REG_CELL_A, a);
        write_seed(REG_CELL_B, bb);
        write_seed(REG_CELL_C, c);
        check_seed(REG_BLOCK_SEED);
        check_seed(REG_CELL_A);
        check_seed(REG_CELL_B);
        check_seed(REG_CELL_C);
        test_random(count);
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        stall_out = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        shadow_seed[REG_BLOCK_SEED] = 4'd0;
        shadow_seed[REG_CELL_A] = 4'd1;
        shadow_seed[REG_CELL_B] = 4'd2;
        shadow_seed[REG_CELL_C] = 4'd3;
        clear_shadow();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        stall_out = 1'b1;
        test_random(300);
        test_seeds(4'd0, 4'd0, 4'd0, 4'd0, 250);
        test_seeds(4'd9, 4'd9, 4'd9, 4'd9, 250);
        test_seeds(4'd15, 4'd7, 4'd4, 4'd12, 250);
        test_seeds(4'd5, 4'd3, 4'd8, 4'd6, 280);
        drain();
        if (error_count == 0)
            $display("flow_filter_count_table_encoder_test passed");
        else
            $display("flow_filter_count_table_encoder_test failed");
        $finish;
    end

endmodule
`default_nettype wire
